### design/fbpa_pkg.sv
// Shared types and codes for the fixed block pool allocator.
package fbpa_pkg;

  localparam int ADDR_W    = 32;
  localparam int SIZE_W    = 21;
  localparam int OP_W      = 2;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 7;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 32;

  // Bitmap words: 32 blocks per RAM word.
  localparam int WORD_W    = 32;
  localparam int WBIT_W    = 5;

  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE = 1'd1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 21'd1024;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [ADDR_W-1:0] address;
  } item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   block_address;
    logic [STATUS_W-1:0] status;
    logic                owned;
    logic [COUNT_W-1:0]  in_use_count;
  } result_t;

endpackage

### design/fbpa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module fbpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### design/fixed_block_pool_allocator_core.sv
// Fixed-size block pool allocator: bitmap in RAM, sequencer, release divider.
// Unused op codes go straight to the result. Query and release first check ownership;
// an owned release then finds the block by restoring division over QW quotient bits (QW
// bitmap index bits, 6 at 64 blocks) and clears its bit. Allocate scans word by word.
// One item at a time; busy is low again in the cycle done_o pulses, so the next
// item may start there. Results cannot be stalled. Reset clears the pool at once
// through per-word valid bits; no clearing pass. base 0, block size 1024.
module fixed_block_pool_allocator_core #(
  parameter int NUM_BLOCKS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  fbpa_pkg::item_t                     item_i,
  output logic                                done_o,
  output fbpa_pkg::result_t                   result_o,
  input  logic                                cfg_we_i,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [fbpa_pkg::CFG_W-1:0]          cfg_wdata_i
);
  import fbpa_pkg::*;

  // Bitmap geometry: word index over NWORDS words, block index = {word, bit}.
  localparam int NWORDS  = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int WA_W    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int QW      = WA_W + WBIT_W;
  localparam int BC_W    = $clog2(NUM_BLOCKS + 1);
  localparam int SPAN_W  = SIZE_W + BC_W;
  localparam int SCMP_W  = (SPAN_W > ADDR_W) ? SPAN_W : ADDR_W;
  localparam int DSH_W   = SIZE_W + QW;
  localparam int DCMP_W  = (DSH_W > ADDR_W) ? DSH_W : ADDR_W;
  localparam int STEP_W  = $clog2(QW + 1);
  localparam int PROD_W  = QW + SIZE_W;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CHECK    = 4'd1;
  localparam logic [3:0] S_OWN      = 4'd2;
  localparam logic [3:0] S_DIV      = 4'd3;
  localparam logic [3:0] S_RD       = 4'd4;
  localparam logic [3:0] S_MOD      = 4'd5;
  localparam logic [3:0] S_SCAN_RD  = 4'd6;
  localparam logic [3:0] S_SCAN_CHK = 4'd7;
  localparam logic [3:0] S_MUL      = 4'd8;
  localparam logic [3:0] S_OUT      = 4'd9;

  logic [3:0]          state_q, state_d;
  logic [ADDR_W-1:0]   base_q;
  logic [SIZE_W-1:0]   size_q;
  logic [OP_W-1:0]     op_q;
  logic [ADDR_W-1:0]   addr_q;
  logic [ADDR_W-1:0]   off_q;
  logic                below_q;
  logic [SPAN_W-1:0]   span_q;
  logic [ADDR_W-1:0]   rem_q;
  logic [DSH_W-1:0]    dsh_q;
  logic [QW-1:0]       quo_q;
  logic [STEP_W-1:0]   step_q;
  logic [WA_W-1:0]     word_q;
  logic [WBIT_W-1:0]   bit_q;
  logic [ADDR_W-1:0]   prod_q;
  logic                found_q;
  logic [STATUS_W-1:0] status_q;
  logic                owned_q;
  logic [BC_W-1:0]     count_q;
  logic [NWORDS-1:0]   wvalid_q;
  logic                done_q;
  result_t             res_q;

  logic [SIZE_W-1:0]   eff_size;
  logic                accept;
  logic                own;
  logic                div_ge;
  logic [WA_W-1:0]     raddr;
  logic [WORD_W-1:0]   rdata;
  logic [WORD_W-1:0]   word_eff;
  logic [WORD_W-1:0]   pad;
  logic [WORD_W-1:0]   avail;
  logic [WBIT_W-1:0]   free_bit;
  logic                ram_we;
  logic [WORD_W-1:0]   ram_wdata;
  logic                last_word;

  // A block size of zero behaves as one.
  assign eff_size = (size_q == '0) ? SIZE_W'(1) : size_q;
  assign accept   = start && !busy;
  assign busy     = (state_q != S_IDLE);

  assign own    = !below_q && (SCMP_W'(off_q) < SCMP_W'(span_q));
  assign div_ge = DCMP_W'(rem_q) >= DCMP_W'(dsh_q);

  // Release reads the word of the quotient; the scan walks word_q.
  assign raddr = (state_q == S_RD) ? quo_q[QW-1:WBIT_W] : word_q;

  // Words never written since reset read as all free.
  assign word_eff  = wvalid_q[word_q] ? rdata : '0;
  assign last_word = (word_q == WA_W'(NWORDS - 1));

  // Bits past the last block count as used so the scan never picks them.
  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      pad[b] = ({1'b0, word_q, WBIT_W'(b)} >= (QW + 1)'(NUM_BLOCKS));
    end
  end

  assign avail = ~(word_eff | pad);

  always_comb begin
    free_bit = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (avail[b]) begin
        free_bit = WBIT_W'(b);
      end
    end
  end

  // Read-modify-write of one bitmap word.
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = word_eff;
    if (state_q == S_SCAN_CHK && |avail) begin
      ram_we              = 1'b1;
      ram_wdata[free_bit] = 1'b1;
    end else if (state_q == S_MOD && word_eff[bit_q]) begin
      ram_we           = 1'b1;
      ram_wdata[bit_q] = 1'b0;
    end
  end

  fbpa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NWORDS)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (word_q),
    .wdata_i (ram_wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (item_i.operation)
            OP_ALLOC:   state_d = S_SCAN_RD;
            OP_RELEASE: state_d = S_CHECK;
            OP_QUERY:   state_d = S_CHECK;
            default:    state_d = S_OUT;
          endcase
        end
      end
      S_CHECK:    state_d = S_OWN;
      S_OWN:      state_d = (op_q == OP_RELEASE && own) ? S_DIV : S_OUT;
      S_DIV:      state_d = (step_q == STEP_W'(1)) ? S_RD : S_DIV;
      S_RD:       state_d = S_MOD;
      S_MOD:      state_d = S_OUT;
      S_SCAN_RD:  state_d = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (|avail) begin
          state_d = S_MUL;
        end else if (last_word) begin
          state_d = S_OUT;
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_MUL:      state_d = S_OUT;
      S_OUT:      state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // Control state and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      base_q   <= '0;
      size_q   <= SIZE_RESET;
      count_q  <= '0;
      wvalid_q <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_OUT);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BASE: base_q <= cfg_wdata_i[ADDR_W-1:0];
          CFG_SIZE: size_q <= cfg_wdata_i[SIZE_W-1:0];
          default:  ;
        endcase
      end
      if (ram_we) begin
        wvalid_q[word_q] <= 1'b1;
        if (state_q == S_SCAN_CHK) begin
          count_q <= count_q + BC_W'(1);
        end else begin
          count_q <= count_q - BC_W'(1);
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        op_q     <= item_i.operation;
        addr_q   <= item_i.address;
        status_q <= ST_OK;
        owned_q  <= 1'b0;
        found_q  <= 1'b0;
        word_q   <= '0;
      end
      S_CHECK: begin
        below_q <= addr_q < base_q;
        off_q   <= addr_q - base_q;
        span_q  <= SPAN_W'(NUM_BLOCKS) * SPAN_W'(eff_size);
      end
      S_OWN: begin
        owned_q <= own;
        if (op_q == OP_RELEASE && !own) begin
          status_q <= ST_OUTSIDE;
        end
        rem_q  <= off_q;
        dsh_q  <= DSH_W'(eff_size) << (QW - 1);
        step_q <= STEP_W'(QW);
      end
      S_DIV: begin
        // Restoring division, one quotient bit per cycle.
        if (div_ge) begin
          rem_q <= ADDR_W'(DCMP_W'(rem_q) - DCMP_W'(dsh_q));
        end
        quo_q  <= {quo_q[QW-2:0], div_ge};
        dsh_q  <= dsh_q >> 1;
        step_q <= step_q - STEP_W'(1);
      end
      S_RD: begin
        word_q <= quo_q[QW-1:WBIT_W];
        bit_q  <= quo_q[WBIT_W-1:0];
      end
      S_SCAN_CHK: begin
        if (|avail) begin
          found_q <= 1'b1;
          bit_q   <= free_bit;
        end else if (last_word) begin
          status_q <= ST_EXHAUSTED;
        end else begin
          word_q <= word_q + WA_W'(1);
        end
      end
      S_MUL: begin
        prod_q <= ADDR_W'(PROD_W'({word_q, bit_q}) * PROD_W'(eff_size));
      end
      S_OUT: begin
        res_q.block_address <= found_q ? (base_q + prod_q) : '0;
        res_q.status        <= status_q;
        res_q.owned         <= owned_q;
        res_q.in_use_count  <= COUNT_W'(count_q);
      end
      default: ;
    endcase
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

### design/fbpa_checker.sv
// Port-level checks for the allocator core, bound to the top level.
module fbpa_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start,
  input logic                           busy,
  input logic                           done_o,
  input fbpa_pkg::result_t              result_o
);
  import fbpa_pkg::*;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("item accepted but block not busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while still busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("two results in a row");

  a_exhausted_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status == ST_EXHAUSTED) |-> (result_o.block_address == '0))
    else $error("address given on exhausted pool");

  a_outside_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status == ST_OUTSIDE) |-> !result_o.owned)
    else $error("outside address reported as owned");

endmodule

bind fixed_block_pool_allocator_core fbpa_checker u_fbpa_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .result_o (result_o)
);
